// ----- rtl/gdad_pkg.sv -----
// Shared types, constants and calendar tables for the Gregorian date adder.
// Used by gdad_ctrl, gdad_dp and gregorian_date_add_days; no dependencies.
package gdad_pkg;

	localparam int ORD_W = 23;

	localparam logic [ORD_W-1:0] DAYS_400   = 23'd146097;
	localparam logic [ORD_W-1:0] CENT_LONG  = 23'd36525;
	localparam logic [ORD_W-1:0] CENT_SHORT = 23'd36524;
	localparam logic [ORD_W-1:0] QUAD_LONG  = 23'd1461;
	localparam logic [ORD_W-1:0] QUAD_SHORT = 23'd1460;
	localparam logic [ORD_W-1:0] YEAR_LONG  = 23'd366;
	localparam logic [ORD_W-1:0] YEAR_SHORT = 23'd365;
	localparam logic [4:0]       FEB_LEAP   = 5'd29;
	localparam logic [12:0]      RECIP_100  = 13'd5243;
	localparam int               RECIP_SH   = 19;

	typedef struct packed {
		logic [13:0] start_year;
		logic [3:0]  start_month;
		logic [4:0]  start_day;
		logic [19:0] day_increment;
	} in_t;

	typedef struct packed {
		logic [13:0] result_year;
		logic [3:0]  result_month;
		logic [4:0]  result_day;
	} out_t;

	typedef enum logic [3:0] {
		ST_NONE, ST_MUL, ST_LEAP, ST_SUM, ST_ORD, ST_DIV,
		ST_CENT, ST_QUAD, ST_YEAR, ST_MON, ST_FIN
	} step_t;

	typedef struct packed {
		logic  load;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic fit;
		logic div_last;
	} stat_t;

	// Days in a month of a common year.
	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] d;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     d = 5'd30;
			4'd2:                                        d = 5'd28;
			default:                                     d = 5'd0;
		endcase
		return d;
	endfunction

	// Days of a common year before the first of month m.
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/gregorian_date_add_days.sv -----
// Top level of the Gregorian date adder: date plus day count.
// Depends on gdad_pkg, gdad_ctrl and gdad_dp.
//
// Usage:
//   Present a date and a day increment on request and raise start. The
//   transaction is accepted at the rising edge where start is high and busy
//   is low; request is sampled at that edge only and may change afterwards.
//   The result date appears on result with done high for exactly one cycle.
//   The receiver cannot stall: capture result while done is high.
// Sequence: after acceptance the block builds the day ordinal (multiply,
//   leap count, sum, minus one), runs the restoring division by the
//   400-year span, then the century, quad, year and month subtract loops,
//   and finally assembles the result.
// Throughput: one transaction at a time; busy drops in the cycle that done
//   is high, so the next start can be accepted in that cycle.
// Reset: arst_n low clears the sequencer to idle and done low; no
//   transaction survives reset. Result registers are not reset.
module gregorian_date_add_days (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  gdad_pkg::in_t  request,
	output logic           done,
	output gdad_pkg::out_t result
);
	import gdad_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer: one state per step, subtract loops held until the datapath stops fitting, the division until its last bit
	gdad_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.cmd    (cmd)
	);

	// datapath: ordinal arithmetic and the shared subtract unit
	gdad_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.stat    (stat),
		.result  (result)
	);

endmodule

// ----- rtl/gdad_ctrl.sv -----
// Sequencing state machine of the Gregorian date adder.
// Depends on gdad_pkg; drives gdad_dp through cmd_t and reads stat_t.
module gdad_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output logic           done,
	input  gdad_pkg::stat_t stat,
	output gdad_pkg::cmd_t  cmd
);
	import gdad_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_MUL  = 11'b00000000010,
		S_LEAP = 11'b00000000100,
		S_SUM  = 11'b00000001000,
		S_ORD  = 11'b00000010000,
		S_DIV  = 11'b00000100000,
		S_CENT = 11'b00001000000,
		S_QUAD = 11'b00010000000,
		S_YEAR = 11'b00100000000,
		S_MON  = 11'b01000000000,
		S_FIN  = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.step = ST_NONE;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.step = ST_MUL;
				state_d  = S_LEAP;
			end
			S_LEAP: begin
				cmd.step = ST_LEAP;
				state_d  = S_SUM;
			end
			S_SUM: begin
				cmd.step = ST_SUM;
				state_d  = S_ORD;
			end
			S_ORD: begin
				cmd.step = ST_ORD;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.step = ST_DIV;
				if (stat.div_last) state_d = S_CENT;
			end
			S_CENT: begin
				cmd.step = ST_CENT;
				if (!stat.fit) state_d = S_QUAD;
			end
			S_QUAD: begin
				cmd.step = ST_QUAD;
				if (!stat.fit) state_d = S_YEAR;
			end
			S_YEAR: begin
				cmd.step = ST_YEAR;
				if (!stat.fit) state_d = S_MON;
			end
			S_MON: begin
				cmd.step = ST_MON;
				if (!stat.fit) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.step = ST_FIN;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not start");
	a_done_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_FIN))
		else $error("result strobe without final step");
`endif

endmodule

// ----- rtl/gdad_dp.sv -----
// Datapath of the Gregorian date adder: day ordinal, 400-year division,
// century/quad/year/month stepping and result assembly. Depends on gdad_pkg.
module gdad_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  gdad_pkg::cmd_t  cmd,
	input  gdad_pkg::in_t   request,
	output gdad_pkg::stat_t stat,
	output gdad_pkg::out_t  result
);
	import gdad_pkg::*;

	// operands
	logic [13:0]      year_q;
	logic [3:0]       smon_q;
	logic [4:0]       day_q;
	logic [19:0]      inc_q;
	// products and ordinal
	logic [27:0]      q1p_q;
	logic [25:0]      q2p_q;
	logic [26:0]      q3p_q;
	logic [ORD_W-1:0] base_q;
	logic [12:0]      leaps_q;
	logic             sleap_q;
	logic [ORD_W-1:0] ord_q;
	out_t             result_q;
	// step counters
	logic [2:0]       div_idx_q;
	logic [5:0]       qt_q;
	logic [1:0]       c_q;
	logic [4:0]       k_q;
	logic [1:0]       j_q;
	logic [3:0]       mon_q;

	logic [3:0]       mon_clamp;
	logic [14:0]      quarter_sum;
	logic [8:0]       q1;
	logic [6:0]       q2;
	logic [7:0]       q3;
	logic [13:0]      hundreds;
	logic             yleap;
	logic             short_quad;
	logic [ORD_W-1:0] div_chunk;
	logic [ORD_W-1:0] chunk;
	logic             fit;
	logic [4:0]       mlen;
	logic [14:0]      year_full;

	always_comb begin
		priority if (request.start_month == 4'd0) mon_clamp = 4'd1;
		else if (request.start_month > 4'd12)     mon_clamp = 4'd12;
		else                                      mon_clamp = request.start_month;
	end

	assign quarter_sum = 15'(year_q) + 15'd3;
	assign q1          = q1p_q[RECIP_SH +: 9];
	assign q2          = q2p_q[RECIP_SH +: 7];
	assign q3          = q3p_q[RECIP_SH +: 8];
	assign hundreds    = 14'(q3) * 14'd100;

	// Century years leap only every fourth century; first year of a quad is the leap one.
	assign short_quad = (k_q == 5'd0) && (c_q != 2'd0);
	assign yleap      = (j_q == 2'd0) && !short_quad;
	assign div_chunk  = DAYS_400 << div_idx_q;
	assign mlen       = (mon_q == 4'd2 && yleap) ? FEB_LEAP : month_len(mon_q);

	always_comb begin
		chunk = '0;
		fit   = 1'b0;
		unique case (cmd.step)
			ST_CENT: begin
				chunk = (c_q == 2'd0) ? CENT_LONG : CENT_SHORT;
				fit   = (c_q != 2'd3) && (ord_q >= chunk);
			end
			ST_QUAD: begin
				chunk = short_quad ? QUAD_SHORT : QUAD_LONG;
				fit   = (ord_q >= chunk);
			end
			ST_YEAR: begin
				chunk = yleap ? YEAR_LONG : YEAR_SHORT;
				fit   = (j_q != 2'd3) && (ord_q >= chunk);
			end
			ST_MON: begin
				chunk = ORD_W'(mlen);
				fit   = (mon_q < 4'd12) && (ord_q >= chunk);
			end
			default: begin
				chunk = '0;
				fit   = 1'b0;
			end
		endcase
	end

	assign stat.fit      = fit;
	assign stat.div_last = (div_idx_q == 3'd0);

	assign year_full = 15'(qt_q) * 15'd400 + 15'(c_q) * 15'd100 + 15'({k_q, 2'b00})
		+ 15'(j_q);

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_idx_q <= '0;
			qt_q      <= '0;
			c_q       <= '0;
			k_q       <= '0;
			j_q       <= '0;
			mon_q     <= 4'd1;
		end else begin
			unique case (cmd.step)
				ST_ORD: begin
					div_idx_q <= 3'd5;
					qt_q      <= '0;
					c_q       <= '0;
					k_q       <= '0;
					j_q       <= '0;
					mon_q     <= 4'd1;
				end
				ST_DIV: begin
					if (ord_q >= div_chunk) qt_q[div_idx_q] <= 1'b1;
					if (div_idx_q != 3'd0) div_idx_q <= div_idx_q - 3'd1;
				end
				ST_CENT: if (fit) c_q <= c_q + 2'd1;
				ST_QUAD: if (fit) k_q <= k_q + 5'd1;
				ST_YEAR: if (fit) j_q <= j_q + 2'd1;
				ST_MON:  if (fit) mon_q <= mon_q + 4'd1;
				default: ;
			endcase
		end
	end

	// (y + 399) / 4, the numerator of the 400-year leap term before division by 100
	function automatic logic [12:0] quarter_sum_399(input logic [13:0] y);
		logic [14:0] s;
		s = 15'(y) + 15'd399;
		return s[14:2];
	endfunction

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q <= request.start_year;
			smon_q <= mon_clamp;
			day_q  <= request.start_day;
			inc_q  <= request.day_increment;
		end
		unique case (cmd.step)
			ST_MUL: begin
				q1p_q  <= 28'(year_q + 14'd0 + 15'd99) * 28'(RECIP_100);
				q2p_q  <= 26'(quarter_sum_399(year_q)) * 26'(RECIP_100);
				q3p_q  <= 27'(year_q) * 27'(RECIP_100);
				base_q <= ORD_W'(year_q) * YEAR_SHORT;
			end
			ST_LEAP: begin
				leaps_q <= quarter_sum[14:2] - 13'(q1) + 13'(q2);
				sleap_q <= (year_q[1:0] == 2'b00) && ((year_q != hundreds) || (q3[1:0] == 2'b00));
			end
			ST_SUM: begin
				ord_q <= base_q + ORD_W'(leaps_q) + ORD_W'(month_start(smon_q))
					+ ORD_W'(sleap_q && (smon_q > 4'd2)) + ORD_W'(day_q) + ORD_W'(inc_q);
			end
			ST_ORD: if (ord_q != '0) ord_q <= ord_q - ORD_W'(1);
			ST_DIV: if (ord_q >= div_chunk) ord_q <= ord_q - div_chunk;
			ST_CENT, ST_QUAD, ST_YEAR, ST_MON: if (fit) ord_q <= ord_q - chunk;
			ST_FIN: begin
				result_q.result_year  <= year_full[13:0];
				result_q.result_month <= mon_q;
				result_q.result_day   <= ord_q[4:0] + 5'd1;
			end
			default: ;
		endcase
	end

	assign result = result_q;

`ifndef SYNTHESIS
	a_quad_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step == ST_QUAD) |-> (k_q <= 5'd24))
		else $error("quad count out of range");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step == ST_CENT) |-> (ord_q < DAYS_400))
		else $error("remainder not below 400-year span");
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mon_q >= 4'd1) && (mon_q <= 4'd12))
		else $error("month counter out of range");
`endif

endmodule

// ----- dv/gregorian_date_add_days_chk.sv -----
// Checker for the Gregorian date adder: predicts each result date and compares it.
// Depends on gdad_pkg for the request and result types and the 400-year span.
`timescale 1ns / 100ps
module gregorian_date_add_days_chk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  gdad_pkg::in_t  request,
	input  logic           done,
	input  gdad_pkg::out_t result,
	output int             mismatches,
	output int             outstanding
);
	import gdad_pkg::*;

	localparam int unsigned COMMON_MONTH [1:12] =
		'{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int          REPORT_LIMIT        = 10;

	out_t expected_dates [$];
	int   mismatch_cnt = 0;

	function automatic bit leap_year(input longint unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic longint unsigned days_of_month(input longint unsigned y, input int m);
		if (m == 2 && leap_year(y))
			return longint'(FEB_LEAP);
		return COMMON_MONTH[m];
	endfunction

	function automatic longint unsigned days_of_year(input longint unsigned y);
		return leap_year(y) ? longint'(YEAR_LONG) : longint'(YEAR_SHORT);
	endfunction

	// Date reached by adding the increment; the day count runs from 1 Jan of year 0.
	function automatic out_t date_after(input in_t req);
		longint unsigned yr;
		longint unsigned day_num;
		longint unsigned y;
		int              mon;
		int              m;
		out_t            d;
		yr  = req.start_year;
		mon = req.start_month;
		if (mon < 1)
			mon = 1;
		if (mon > 12)
			mon = 12;
		day_num = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
		for (m = 1; m < mon; m++)
			day_num += days_of_month(yr, m);
		day_num += longint'(req.start_day) + longint'(req.day_increment);
		// day zero before the first date saturates
		day_num = (day_num == 0) ? 0 : day_num - 1;
		y       = (day_num / longint'(DAYS_400)) * 400;
		day_num = day_num % longint'(DAYS_400);
		while (day_num >= days_of_year(y)) begin
			day_num -= days_of_year(y);
			y++;
		end
		m = 1;
		while (m < 12 && day_num >= days_of_month(y, m)) begin
			day_num -= days_of_month(y, m);
			m++;
		end
		d.result_year  = y[13:0];
		d.result_month = m[3:0];
		d.result_day   = 5'(day_num + 1);
		return d;
	endfunction

	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_dates.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= REPORT_LIMIT)
						$display("%0t: unexpected result %0d-%0d-%0d", $time,
							result.result_year, result.result_month, result.result_day);
				end else begin
					want = expected_dates.pop_front();
					if (result.result_year !== want.result_year ||
							result.result_month !== want.result_month ||
							result.result_day !== want.result_day) begin
						mismatch_cnt++;
						if (mismatch_cnt <= REPORT_LIMIT)
							$display("%0t: expected %0d-%0d-%0d, got %0d-%0d-%0d", $time,
								want.result_year, want.result_month, want.result_day,
								result.result_year, result.result_month, result.result_day);
					end
				end
			end
			if (start && !busy)
				expected_dates.push_back(date_after(request));
		end
		mismatches  <= mismatch_cnt;
		outstanding <= expected_dates.size();
	end

endmodule

// ----- dv/gregorian_date_add_days_tb.sv -----
// Testbench top for the Gregorian date adder: drives date transactions and gives the verdict.
// Depends on gdad_pkg, gregorian_date_add_days and gregorian_date_add_days_chk.
`timescale 1ns / 100ps
module gregorian_date_add_days_tb;
	import gdad_pkg::*;

	localparam int RANDOM_DATES   = 800;
	localparam int WATCHDOG_LIMIT = 4000;  // worst random gap plus the longest latency, with margin
	localparam int DRAIN_CYCLES   = 64;    // covers the block's longest latency

	logic clk     = 1'b0;
	logic arst_n  = 1'b0;
	logic start   = 1'b0;
	in_t  request = '0;
	logic busy;
	logic done;
	out_t result;
	int   mismatches;
	int   outstanding;
	int   stall_cycles = 0;
	bit   quiet        = 1'b0;
	in_t  corner_dates [$];

	always #1 clk = ~clk;

	gregorian_date_add_days u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	gregorian_date_add_days_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.done        (done),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Watchdog: end the run once nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("gregorian_date_add_days: mismatch");
			$finish;
		end
	end

	function automatic in_t pack_date(input int y, input int m, input int d, input int inc);
		in_t r;
		r.start_year    = 14'(y);
		r.start_month   = 4'(m);
		r.start_day     = 5'(d);
		r.day_increment = 20'(inc);
		return r;
	endfunction

	// Mostly well-formed dates in the usual year range; now and then any bit pattern.
	function automatic in_t random_date();
		in_t r;
		int  spread;
		r.start_year  = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(9999));
		r.start_month = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(12, 1));
		case ($urandom_range(9))
			0:       r.start_day = 5'($urandom);
			1, 2:    r.start_day = 5'($urandom_range(31, 1));
			default: r.start_day = 5'($urandom_range(28, 1));
		endcase
		spread = $urandom_range(3);
		case (spread)
			0:       r.day_increment = 20'($urandom_range(31));
			1:       r.day_increment = 20'($urandom_range(400));
			2:       r.day_increment = 20'($urandom_range(50000));
			default: r.day_increment = 20'($urandom);
		endcase
		return r;
	endfunction

	// Present one transaction and hold it until accepted; then maybe go quiet for a while.
	task automatic send_date(input in_t item);
		request <= item;
		start   <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (!quiet && $urandom_range(99) < 6) begin
			start <= 1'b0;
			// random gap lands the next start at any point of the block's work
			repeat ($urandom_range(60, 1)) @(posedge clk);
		end
	endtask

	// Hold off the sender until every outstanding date has come back.
	task automatic drain_dates();
		start <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	initial begin
		int i;
		// leap rules, saturation at the first date, month clamping, overflowing days
		corner_dates.push_back(pack_date(0, 1, 0, 0));
		corner_dates.push_back(pack_date(0, 1, 1, 0));
		corner_dates.push_back(pack_date(1, 1, 0, 0));
		corner_dates.push_back(pack_date(2000, 2, 28, 1));
		corner_dates.push_back(pack_date(1900, 2, 28, 1));
		corner_dates.push_back(pack_date(2100, 2, 29, 0));
		corner_dates.push_back(pack_date(2000, 2, 29, 366));
		corner_dates.push_back(pack_date(1999, 12, 31, 1));
		corner_dates.push_back(pack_date(2024, 4, 31, 0));
		corner_dates.push_back(pack_date(2023, 0, 15, 10));
		corner_dates.push_back(pack_date(2023, 13, 1, 0));
		corner_dates.push_back(pack_date(2023, 14, 31, 31));
		corner_dates.push_back(pack_date(2023, 15, 0, 0));
		corner_dates.push_back(pack_date(9999, 12, 31, 1));
		corner_dates.push_back(pack_date(9999, 12, 31, 20'hFFFFF));
		corner_dates.push_back(pack_date(16383, 12, 31, 20'hFFFFF));
		corner_dates.push_back(pack_date(16383, 15, 31, 20'hFFFFF));
		corner_dates.push_back(pack_date(1600, 3, 1, 146097));
		corner_dates.push_back(pack_date(0, 1, 1, 20'hFFFFF));
		corner_dates.push_back(pack_date(2024, 3, 0, 0));
		corner_dates.push_back(pack_date(1, 3, 1, 365));
		corner_dates.push_back(pack_date(399, 12, 31, 1));

		// release reset once
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_dates[k])
			send_date(corner_dates[k]);
		drain_dates();

		for (i = 0; i < RANDOM_DATES; i++) begin
			// run a long back-to-back stretch in the middle
			if (i == 300)
				quiet = 1'b1;
			if (i == 500)
				quiet = 1'b0;
			if (i == 150)
				drain_dates();
			send_date(random_date());
		end

		// drop start and let the last transactions complete
		start <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("gregorian_date_add_days: match");
		else
			$display("gregorian_date_add_days: mismatch");
		$finish;
	end

endmodule
